>>> design/phnm_pkg.sv
`timescale 1ns / 1ps

package phnm_pkg;

    localparam int TIME_W       = 63;
    localparam int POSE_W       = 64;
    localparam int POSE_WORDS   = 6;
    localparam int POSE_BUS_W   = POSE_W * POSE_WORDS;
    localparam int TDATA_W      = 448;
    localparam int PAD_W        = TDATA_W - TIME_W - POSE_BUS_W;
    localparam int LIMIT_W      = 12;
    localparam int CAPACITY_DEF = 2048;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;

    typedef enum logic [0:0] {
        OP_PUSH  = 1'b0,
        OP_QUERY = 1'b1
    } op_e_t;

    // one classified request; pose words with x in the lowest bits
    typedef struct packed {
        op_e_t                 op;
        logic [TIME_W-1:0]     time_stamp;
        logic [POSE_BUS_W-1:0] pose;
    } item_t;

    typedef struct packed {
        logic idle;
        logic empty;
        logic trim;
    } back_stat_t;

endpackage

>>> design/phnm_ram.sv
`timescale 1ns / 1ps

module phnm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/phnm_queue.sv
`timescale 1ns / 1ps

module phnm_queue import phnm_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0]   LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

    item_t           mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> design/phnm_front.sv
`timescale 1ns / 1ps

module phnm_front import phnm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,
    input  logic [0:0]         s_axis_tuser,
    output logic               out_valid,
    input  logic               out_ready,
    output item_t              out_item
);

    logic  full_reg, full_next;
    item_t item_reg;
    item_t item_dec;
    logic  accept;

    // decode the kind of request and split the payload
    always_comb
    begin
        item_dec.op         = op_e_t'(s_axis_tuser[0]);
        item_dec.time_stamp = s_axis_tdata[TIME_W-1:0];
        item_dec.pose       = s_axis_tdata[TIME_W +: POSE_BUS_W];
    end

    assign s_axis_tready = !full_reg || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_valid     = full_reg;
    assign out_item      = item_reg;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (out_ready)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_dec;
        end
    end

endmodule

>>> design/phnm_back.sv
`timescale 1ns / 1ps

module phnm_back import phnm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    input  logic [LIMIT_W-1:0] retain_limit,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]         m_axis_tuser,
    output back_stat_t         stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_PUSH_TRIM = 9'b000000010,
        ST_SRCH_ADDR = 9'b000000100,
        ST_SRCH_CMP  = 9'b000001000,
        ST_SEL       = 9'b000010000,
        ST_NEIGH_A   = 9'b000100000,
        ST_NEIGH_B   = 9'b001000000,
        ST_FETCH     = 9'b010000000,
        ST_DELIVER   = 9'b100000000
    } back_state_t;

    // (base + pos) mod CAPACITY, base < CAPACITY and pos <= CAPACITY
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                                input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(pos);
        if (sum >= CAP_S)
        begin
            sum = sum - CAP_S;
        end
        return sum[AW-1:0];
    endfunction

    back_state_t state_reg, state_next;
    logic [AW-1:0]         oldest_reg, oldest_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [TIME_W-1:0]     t_reg, t_next;
    logic [TIME_W-1:0]     ta_reg, ta_next;
    logic [AW-1:0]         sel_slot_reg, sel_slot_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [POSE_BUS_W-1:0] out_pose_reg;

    logic [LW-1:0]         lim_ext;
    logic [CW-1:0]         lim;
    logic                  full;
    logic                  pop;
    logic [CW-1:0]         wrap_pos;
    logic [AW-1:0]         wrap_slot;
    logic [SW-1:0]         mid_sum;
    logic [CW-1:0]         mid_inc;
    logic [CW-1:0]         lo_new, hi_new;
    logic                  less;
    logic [TIME_W:0]       two_t, ab_sum;
    logic                  out_load;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [TIME_W-1:0]     rd_time;
    logic [POSE_BUS_W-1:0] rd_pose;

    // effective limit, clamped to [1, CAPACITY]
    always_comb
    begin
        lim_ext = LW'(retain_limit);
        if (lim_ext == '0)
        begin
            lim_ext = LW'(1);
        end
        else if (lim_ext > CAP_L)
        begin
            lim_ext = CAP_L;
        end
        lim = lim_ext[CW-1:0];
    end

    assign full       = (count_reg >= CAP_C);
    assign item_ready = (state_reg == ST_IDLE);
    assign pop        = item_valid && item_ready;
    assign mid_sum    = SW'(lo_reg) + SW'(hi_reg);
    assign mid_inc    = mid_reg + CW'(1);
    assign less       = (rd_time < t_reg);
    assign lo_new     = less ? mid_inc : lo_reg;
    assign hi_new     = less ? hi_reg : mid_reg;
    assign two_t      = {t_reg, 1'b0};
    assign ab_sum     = {1'b0, ta_reg} + {1'b0, rd_time};
    assign out_load   = !out_valid_reg || m_axis_tready;

    // one shared ring adder, position chosen by state
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:      wrap_pos = full ? CW'(1) : count_reg;
            ST_PUSH_TRIM: wrap_pos = count_reg - lim;
            ST_SRCH_ADDR: wrap_pos = mid_sum[SW-1:1];
            ST_SEL:       wrap_pos = lo_reg - CW'(1);
            ST_NEIGH_A:   wrap_pos = lo_reg;
            ST_NEIGH_B:   wrap_pos = lo_reg;
            default:      wrap_pos = count_reg;
        endcase
    end

    assign wrap_slot = ring_slot(oldest_reg, wrap_pos);

    assign wr_en   = pop && (item.op == OP_PUSH);
    assign wr_addr = full ? oldest_reg : wrap_slot;

    always_comb
    begin
        unique case (state_reg)
            ST_SRCH_ADDR, ST_SEL, ST_NEIGH_A: rd_addr = wrap_slot;
            default:                          rd_addr = sel_slot_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        t_next        = t_reg;
        ta_next       = ta_reg;
        sel_slot_next = sel_slot_reg;
        found_next    = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (item.op == OP_PUSH)
                    begin
                        oldest_next = full ? wrap_slot : oldest_reg;
                        count_next  = full ? count_reg : count_reg + CW'(1);
                        state_next  = ST_PUSH_TRIM;
                    end
                    else
                    begin
                        t_next     = item.time_stamp;
                        lo_next    = '0;
                        hi_next    = count_reg;
                        found_next = (count_reg != '0);
                        state_next = (count_reg != '0) ? ST_SRCH_ADDR : ST_DELIVER;
                    end
                end
            end
            ST_PUSH_TRIM:
            begin
                if (count_reg > lim)
                begin
                    oldest_next = wrap_slot;
                    count_next  = lim;
                end
                state_next = ST_IDLE;
            end
            ST_SRCH_ADDR:
            begin
                mid_next   = mid_sum[SW-1:1];
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                lo_next    = lo_new;
                hi_next    = hi_new;
                state_next = (lo_new < hi_new) ? ST_SRCH_ADDR : ST_SEL;
            end
            ST_SEL:
            begin
                if (lo_reg == '0)
                begin
                    sel_slot_next = oldest_reg;
                    state_next    = ST_FETCH;
                end
                else if (lo_reg >= count_reg)
                begin
                    sel_slot_next = wrap_slot;
                    state_next    = ST_FETCH;
                end
                else
                begin
                    sel_slot_next = wrap_slot;
                    state_next    = ST_NEIGH_A;
                end
            end
            ST_NEIGH_A:
            begin
                ta_next    = rd_time;
                state_next = ST_NEIGH_B;
            end
            ST_NEIGH_B:
            begin
                // tie goes to the older neighbour
                if (two_t > ab_sum)
                begin
                    sel_slot_next = wrap_slot;
                end
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_DELIVER) && out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        t_reg        <= t_next;
        ta_reg       <= ta_next;
        sel_slot_reg <= sel_slot_next;
        found_reg    <= found_next;
        if ((state_reg == ST_DELIVER) && out_load)
        begin
            out_found_reg <= found_reg;
            out_time_reg  <= found_reg ? rd_time : '0;
            out_pose_reg  <= found_reg ? rd_pose : '0;
        end
    end

    phnm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CAPACITY)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.time_stamp),
        .rd_addr (rd_addr),
        .rd_data (rd_time)
    );

    phnm_ram #(
        .WIDTH (POSE_BUS_W),
        .DEPTH (CAPACITY)
    ) u_pose_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.pose),
        .rd_addr (rd_addr),
        .rd_data (rd_pose)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {{PAD_W{1'b0}}, out_pose_reg, out_time_reg};
    assign m_axis_tuser[0] = out_found_reg;

    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.empty = (count_reg == '0);
    assign stat.trim  = (state_reg == ST_PUSH_TRIM);

endmodule

>>> design/pose_history_nearest_match.sv
// Push: in the back end, a ring write, then a trim to the retain limit.
// Query: a binary search over the n samples held, each step an address and a compare on
//   the registered time RAM read, then select, a neighbour read, fetch and the output load.
// One request is worked at a time; a 2-deep queue and an input stage take more meanwhile.
// Reset (rst_n, async, low): store empty, ring start at slot 0, retain limit 2000;
//   RAM contents are not cleared, as only written slots are ever read.
`timescale 1ns / 1ps

module pose_history_nearest_match import phnm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [62:0] time_stamp, [126:63] pose_x, [190:127] pose_y, [254:191] pose_z,
    // [318:255] pose_rx, [382:319] pose_ry, [446:383] pose_rz, [447] zero
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // [0] operation: 0 push, 1 query
    input  logic [0:0]         s_axis_tuser,
    // result stream, one per query
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [62:0] matched_time, [126:63] match_x, [190:127] match_y, [254:191] match_z,
    // [318:255] match_rx, [382:319] match_ry, [446:383] match_rz, [447] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic [0:0]         m_axis_tuser,
    // retain limit register
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    logic [LIMIT_W-1:0] retain_limit_reg;

    // front stage -> queue
    logic  fr_valid, fr_ready;
    item_t fr_item;
    // queue -> back end
    logic  q_valid, q_ready;
    item_t q_item;
    back_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retain_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            retain_limit_reg <= cfg_wr_data;
        end
    end

    // front: takes requests and decodes push / query
    phnm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_item      (fr_item)
    );

    // short decoupling queue
    phnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back end: ring store, binary search, output register
    phnm_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (q_valid),
        .item_ready    (q_ready),
        .item          (q_item),
        .retain_limit  (retain_limit_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .stat          (stat)
    );

`ifndef SYNTHESIS
    // a miss carries an all-zero sample
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss result with non-zero payload");

    // a new result only follows back-end work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!stat.idle))
        else $error("result raised while back end was idle");

    // after any push the store holds at least one sample
    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.trim |=> !stat.empty)
        else $error("store empty after push");
`endif

endmodule

>>> test/pose_history_nearest_match_tb.sv
`timescale 1ns / 1ps

module pose_history_nearest_match_tb;
    import phnm_pkg::*;

    localparam int                CAP           = CAPACITY_DEF;
    localparam logic [TIME_W-1:0] T_MAX         = {TIME_W{1'b1}};
    // must cover a push and a full-depth search; a few requests can sit queued
    localparam int                SETTLE_CYCLES = 100;
    localparam int                MAX_REPORTS   = 40;
    localparam int                PHASES        = 12;
    localparam int                PHASE_ITEMS   = 146;

    // one expected result: found flag, matched time, six pose words (x lowest)
    typedef struct packed {
        logic                  found;
        logic [TIME_W-1:0]     stamp;
        logic [POSE_BUS_W-1:0] pose;
    } match_t;

    // Shadow of the pose history: ring of samples, lower-bound search, nearest pick.
    // Requests are logged in acceptance order; results are checked oldest first.
    class pose_match_checker;
        logic [TIME_W-1:0]     stamps [CAP];
        logic [POSE_BUS_W-1:0] poses  [CAP];
        int unsigned           oldest;
        int unsigned           held;
        logic [LIMIT_W-1:0]    limit;
        match_t                awaited [$];
        int                    mismatches;
        string                 labels [POSE_WORDS];

        function new();
            oldest     = 0;
            held       = 0;
            limit      = LIMIT_RESET;
            mismatches = 0;
            labels     = '{"match_x", "match_y", "match_z", "match_rx", "match_ry", "match_rz"};
        endfunction

        function int unsigned slot_of(int unsigned pos);
            return (oldest + pos) % CAP;
        endfunction

        function logic [TIME_W-1:0] stamp_at(int unsigned pos);
            return stamps[slot_of(pos)];
        endfunction

        function match_t pick(int unsigned slot);
            match_t m;
            m.found = 1'b1;
            m.stamp = stamps[slot];
            m.pose  = poses[slot];
            return m;
        endfunction

        function void log_request(op_e_t op, logic [TIME_W-1:0] t,
                                  logic [POSE_BUS_W-1:0] pose);
            int unsigned   slot;
            int unsigned   lim;
            int unsigned   lo;
            int unsigned   hi;
            int unsigned   mid;
            logic [TIME_W:0] twice;
            logic [TIME_W:0] pair;
            match_t        m;
            if (op == OP_PUSH)
            begin
                // full ring: overwrite the oldest and step past it
                if (held >= CAP)
                begin
                    held   = CAP;
                    slot   = oldest;
                    oldest = slot_of(1);
                end
                else
                begin
                    slot = slot_of(held);
                    held++;
                end
                stamps[slot] = t;
                poses[slot]  = pose;
                // limit clamped to 1..CAP; trimming only happens here, never on the write
                lim = 32'(limit);
                if (lim < 1)
                    lim = 1;
                if (lim > CAP)
                    lim = CAP;
                if (held > lim)
                begin
                    oldest = slot_of(held - lim);
                    held   = lim;
                end
                return;
            end
            if (held == 0)
            begin
                m = '0;
                awaited.insert(awaited.size(), m);
                return;
            end
            lo = 0;
            hi = held;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (stamp_at(mid) < t)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == 0)
                m = pick(slot_of(0));
            else if (lo >= held)
                m = pick(slot_of(held - 1));
            else
            begin
                // tie goes to the older sample; sums kept exact in 64 bits
                twice = {1'b0, t} + {1'b0, t};
                pair  = {1'b0, stamp_at(lo - 1)} + {1'b0, stamp_at(lo)};
                m = (twice <= pair) ? pick(slot_of(lo - 1)) : pick(slot_of(lo));
            end
            awaited.insert(awaited.size(), m);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s: got %h, expected %h", $time, field, got, want);
        endtask

        task check_match(logic found, logic [TDATA_W-1:0] data);
            match_t want;
            match_t got;
            got.found = found;
            got.stamp = data[TIME_W-1:0];
            got.pose  = data[TIME_W +: POSE_BUS_W];
            if (awaited.size() == 0)
            begin
                report_mismatch("result with none awaited", 64'(found), 64'(0));
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (got.found !== want.found)
                report_mismatch("found", 64'(got.found), 64'(want.found));
            if (got.stamp !== want.stamp)
                report_mismatch("matched_time", 64'(got.stamp), 64'(want.stamp));
            for (int w = 0; w < POSE_WORDS; w++)
                if (got.pose[w*POSE_W +: POSE_W] !== want.pose[w*POSE_W +: POSE_W])
                    report_mismatch(labels[w], got.pose[w*POSE_W +: POSE_W],
                                    want.pose[w*POSE_W +: POSE_W]);
        endtask
    endclass

    // ---------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ---------------------------------------------------------------------
    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;
    logic               cfg_wr_en     = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data   = '0;

    pose_match_checker  board = new();

    // idle odds in percent: request side gaps, result side stalls
    int                 source_gap_pct = 0;
    int                 sink_stall_pct = 0;
    // running sample time for well-ordered pushes
    logic [TIME_W-1:0]  stamp_cursor   = 63'd5000;

    // one limit per phase: extremes, zero (acts as one), over-range, and a few ordinary
    logic [LIMIT_W-1:0] phase_limits [PHASES] = '{12'd1, 12'd0, 12'd7, 12'd2048,
                                                  12'd3, 12'd40, 12'd2, 12'd2047,
                                                  12'd4095, 12'd12, 12'd100, 12'd2000};

    pose_history_nearest_match uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: tready changes on the falling edge, handshake seen on the rising one
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_match(m_axis_tuser[0], m_axis_tdata);

    // ---------------------------------------------------------------------
    // random values
    // ---------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [POSE_BUS_W-1:0] rand_pose();
        logic [POSE_BUS_W-1:0] p;
        for (int w = 0; w < POSE_WORDS; w++)
            p[w*POSE_W +: POSE_W] = {$urandom(), $urandom()};
        return p;
    endfunction

    // next time for an in-order push: mostly small steps, some repeats, some big jumps;
    // restarts low (so out of order) only when the 63-bit range would run out
    function automatic logic [TIME_W-1:0] next_stamp();
        logic [TIME_W-1:0] step;
        case ($urandom_range(0, 9))
            0:       step = '0;
            8:       step = TIME_W'($urandom_range(1000, 1 << 30));
            9:       step = TIME_W'($urandom());
            default: step = TIME_W'($urandom_range(1, 1000));
        endcase
        if (T_MAX - stamp_cursor < step)
            stamp_cursor = TIME_W'($urandom_range(0, 1000));
        else
            stamp_cursor = stamp_cursor + step;
        return stamp_cursor;
    endfunction

    // asked time aimed at the samples held: exact hits, midpoints (ties),
    // below the oldest, above the newest, and just past a sample
    function automatic logic [TIME_W-1:0] near_query();
        int unsigned       pos;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] t;
        logic [TIME_W:0]   pair;
        if (board.held == 0)
            return rand63();
        pos = $urandom_range(0, board.held - 1);
        d   = TIME_W'($urandom_range(0, 3000));
        a   = board.stamp_at(pos);
        case ($urandom_range(0, 4))
            0: t = a;
            1:
            begin
                if (pos + 1 < board.held)
                begin
                    b    = board.stamp_at(pos + 1);
                    pair = {1'b0, a} + {1'b0, b};
                    t    = pair[TIME_W:1] + TIME_W'($urandom_range(0, 1));
                end
                else
                    t = a;
            end
            2:
            begin
                a = board.stamp_at(0);
                t = (a > d) ? a - d : '0;
            end
            3:
            begin
                b = board.stamp_at(board.held - 1);
                t = (T_MAX - b > d) ? b + d : T_MAX;
            end
            default: t = (T_MAX - a > d) ? a + d : a;
        endcase
        return t;
    endfunction

    // ---------------------------------------------------------------------
    // request side: drive on the falling edge, accept on the rising edge
    // ---------------------------------------------------------------------
    task automatic send_request(input op_e_t op, input logic [TIME_W-1:0] stamp,
                                input logic [POSE_BUS_W-1:0] pose);
        @(negedge clk);
        while ($urandom_range(0, 99) < source_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, pose, stamp};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.log_request(op, stamp, pose);
    endtask

    task automatic push_sample(input logic [TIME_W-1:0] stamp,
                               input logic [POSE_BUS_W-1:0] pose);
        send_request(OP_PUSH, stamp, pose);
    endtask

    // pose words of a query are ignored by the block, so they carry noise
    task automatic ask_nearest(input logic [TIME_W-1:0] stamp);
        send_request(OP_QUERY, stamp, rand_pose());
    endtask

    task automatic wait_for_matches();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    // limit is only written with the block idle; trailing pushes give no result,
    // so allow them time to retire before the write
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_for_matches();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        board.limit = value;
    endtask

    // mostly in-order pushes and aimed queries, with some out-of-order pushes
    // and wholly random queries as noise
    task automatic random_requests(input int count, input bit pause_midway);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_for_matches();
            roll = $urandom_range(0, 99);
            if (roll < 45)
                push_sample(next_stamp(), rand_pose());
            else if (roll < 88)
                ask_nearest(near_query());
            else if (roll < 94)
                push_sample(rand63(), rand_pose());
            else
                ask_nearest(rand63());
        end
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset limit of 2000, no idling
        ask_nearest(63'd5);                                 // empty store: not found
        push_sample(63'd1000, {POSE_BUS_W{1'b1}});
        ask_nearest(63'd0);                                 // single sample
        push_sample(63'd2000, '0);
        push_sample(63'd3000, {POSE_WORDS{64'hAAAA_AAAA_AAAA_AAAA}});
        ask_nearest(63'd1500);                              // exact tie: older wins
        ask_nearest(63'd1501);
        ask_nearest(63'd2000);                              // exact hit
        ask_nearest(T_MAX);                                 // after newest
        ask_nearest(63'd0);                                 // before oldest
        push_sample(63'd3000, {POSE_WORDS{64'h5555_5555_5555_5555}}); // repeated time
        ask_nearest(63'd3000);                              // first of the equal pair
        ask_nearest(63'd2500);
        push_sample(T_MAX, rand_pose());                    // top of the time range
        ask_nearest(T_MAX - 63'd1);
        ask_nearest(T_MAX);
        push_sample(63'd10, rand_pose());                   // out of time order
        ask_nearest(63'd10);
        ask_nearest(63'd5);
        ask_nearest(T_MAX - 63'd10);

        // random phases: receiver mostly stalling, then sender mostly idle, then neither
        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 4)
                0:
                begin
                    source_gap_pct = 9;
                    sink_stall_pct = 86;
                end
                1:
                begin
                    source_gap_pct = 86;
                    sink_stall_pct = 9;
                end
                default:
                begin
                    source_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            write_limit(phase_limits[p]);
            // near the top of the time range, so sums of times use the top bit
            if (p == PHASES - 2)
                stamp_cursor = T_MAX - (63'd1 << 36);
            random_requests(PHASE_ITEMS, (p % 3) == 1);
        end

        wait_for_matches();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
